>>> sv/psfp_pkg.sv
// ----------------------------------------------------------------------------
// psfp_pkg
// Shared types, constants and helpers of the particle sensor frame parser.
// ----------------------------------------------------------------------------
package psfp_pkg;

    // Default frame length in bytes and the reset value of the start byte.
    localparam int FRAME_BYTES_DEF = 32;
    localparam logic [7:0] START_BYTE_RST = 8'd66;

    // The result run of one frame never holds more than this many words.
    localparam int MAX_WORDS = 15;

    // Width of a word index and of a word value.
    localparam int IDX_W  = 4;
    localparam int WORD_W = 16;
    localparam int SUM_W  = 16;

    // Number of words reported for a frame of fb bytes.
    function automatic int calc_nwords(input int fb);
        int n;
        n = (fb - 2) >> 1;
        if (n > MAX_WORDS) begin
            n = MAX_WORDS;
        end
        return n;
    endfunction

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECV,
        ST_RD_HI,
        ST_RD_LO,
        ST_LOAD,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start_frame;
        logic store_byte;
        logic complete;
        logic rd_lo;
        logic latch_hi;
        logic load_out;
        logic next_word;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_start;
        logic pos_last;
        logic word_last;
    } t_status;

endpackage

>>> sv/psfp_ctrl.sv
// ----------------------------------------------------------------------------
// psfp_ctrl
// Sequencer: collects frame bytes, then steps through the word reads and
// output transfers of a finished frame.
// ----------------------------------------------------------------------------
module psfp_ctrl
    import psfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_rx_valid,
    output logic    o_rx_ready,
    output logic    o_word_valid,
    input  logic    i_word_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_rx_valid && i_status.is_start) begin
                    n_state = ST_RECV;
                end
            end
            ST_RECV: begin
                if (i_rx_valid && i_status.pos_last) begin
                    n_state = ST_RD_HI;
                end
            end
            ST_RD_HI: n_state = ST_RD_LO;
            ST_RD_LO: n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_OUT;
            ST_OUT: begin
                if (i_word_ready) begin
                    n_state = i_status.word_last ? ST_IDLE : ST_RD_HI;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_rx_ready   = 1'b0;
        o_word_valid = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_rx_ready        = 1'b1;
                o_cmd.start_frame = i_rx_valid && i_status.is_start;
            end
            ST_RECV: begin
                o_rx_ready       = 1'b1;
                o_cmd.store_byte = i_rx_valid;
                o_cmd.complete   = i_rx_valid && i_status.pos_last;
            end
            ST_RD_HI: o_cmd.rd_lo = 1'b0;
            ST_RD_LO: begin
                o_cmd.rd_lo    = 1'b1;
                o_cmd.latch_hi = 1'b1;
            end
            ST_LOAD: o_cmd.load_out = 1'b1;
            ST_OUT: begin
                o_word_valid    = 1'b1;
                o_cmd.next_word = i_word_ready;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> sv/psfp_dpath.sv
// ----------------------------------------------------------------------------
// psfp_dpath
// Frame store, position counter, running sum, checksum check and the
// output register of the word stream.
// ----------------------------------------------------------------------------
module psfp_dpath
    import psfp_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    input  logic [7:0]        i_rx_byte,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    output logic [IDX_W-1:0]  o_word_index,
    output logic [WORD_W-1:0] o_word_value,
    output logic              o_checksum_ok,
    output logic              o_last
);

    localparam int AW     = $clog2(FRAME_BYTES);
    localparam int NWORDS = calc_nwords(FRAME_BYTES);

    logic [7:0]        r_mem [FRAME_BYTES];
    logic [7:0]        r_rd_data;
    logic [AW-1:0]     rd_addr;

    logic [7:0]        r_start_byte;
    logic [AW-1:0]     r_pos;
    logic [SUM_W-1:0]  r_sum;
    logic [7:0]        r_chk_hi;
    logic              r_ok;
    logic [IDX_W-1:0]  r_k;
    logic [7:0]        r_hi;

    logic [IDX_W-1:0]  r_word_index;
    logic [WORD_W-1:0] r_word_value;
    logic              r_checksum_ok;
    logic              r_last;

    logic              word_last;

    assign word_last = (r_k == IDX_W'(NWORDS - 1));

    assign o_status.is_start  = (i_rx_byte == r_start_byte);
    assign o_status.pos_last  = (r_pos == AW'(FRAME_BYTES - 1));
    assign o_status.word_last = word_last;

    // Word k sits at bytes 2+2k (high) and 3+2k (low).
    assign rd_addr = AW'({r_k, i_cmd.rd_lo}) + AW'(2);

    // Frame store: one write port for incoming bytes, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_frame || i_cmd.store_byte) begin
            r_mem[r_pos] <= i_rx_byte;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
            r_pos        <= '0;
            r_sum        <= '0;
            r_k          <= '0;
        end else begin
            if (i_cfg_we) begin
                r_start_byte <= i_cfg_wdata;
            end
            if (i_cmd.start_frame) begin
                r_pos <= AW'(1);
                r_sum <= {8'h00, i_rx_byte};
            end else if (i_cmd.complete) begin
                r_pos <= '0;
                r_sum <= '0;
                r_k   <= '0;
            end else if (i_cmd.store_byte) begin
                r_pos <= r_pos + AW'(1);
                if (r_pos < AW'(FRAME_BYTES - 2)) begin
                    r_sum <= r_sum + {8'h00, i_rx_byte};
                end
            end
            if (i_cmd.next_word) begin
                r_k <= r_k + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_byte && (r_pos == AW'(FRAME_BYTES - 2))) begin
            r_chk_hi <= i_rx_byte;
        end
        if (i_cmd.complete) begin
            r_ok <= (r_sum == {r_chk_hi, i_rx_byte});
        end
        if (i_cmd.latch_hi) begin
            r_hi <= r_rd_data;
        end
        if (i_cmd.load_out) begin
            r_word_index  <= r_k;
            r_word_value  <= {r_hi, r_rd_data};
            r_checksum_ok <= r_ok;
            r_last        <= word_last;
        end
    end

    assign o_word_index  = r_word_index;
    assign o_word_value  = r_word_value;
    assign o_checksum_ok = r_checksum_ok;
    assign o_last        = r_last;

endmodule

>>> sv/particle_sensor_frame_parser_core.sv
// ----------------------------------------------------------------------------
// particle_sensor_frame_parser_core
// Parses fixed-length particle sensor frames from a received byte stream.
// ----------------------------------------------------------------------------
// The core takes one received byte per transfer on the rx channel. While idle
// it drops every byte that differs from the programmable start byte (reset
// value 66); a matching byte opens a frame of FRAME_BYTES bytes. Each frame
// byte is taken when offered and written to a small frame store while a
// running 16-bit sum of all bytes but the last two is kept. The last two
// bytes form the checksum word. When the final byte of a frame is taken the
// core drops rx ready and reports the big-endian words built from byte 2
// onward, (FRAME_BYTES-2)/2 of them capped at 15, one word per output
// transfer with its index, the checksum-ok flag and a last mark on the final
// word. The frame store has a single registered read port, so each word costs
// two reads, one load into the output register and the transfer itself, and
// a stall on the output side holds the burst. The start byte is to be written
// through the configuration port only while the core is idle; the core itself
// does not enforce this, and a change only affects the next start detection.
// ----------------------------------------------------------------------------
module particle_sensor_frame_parser_core
    import psfp_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration: start byte.
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    // Received bytes.
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [7:0]        i_rx_byte,
    // Parsed words.
    output logic              o_word_valid,
    input  logic              i_word_ready,
    output logic [IDX_W-1:0]  o_word_index,
    output logic [WORD_W-1:0] o_word_value,
    output logic              o_checksum_ok,
    output logic              o_last
);

    localparam int NWORDS = calc_nwords(FRAME_BYTES);

    t_cmd    cmd;
    t_status status;

    // The sequencer decides when bytes are taken and when words are read out.
    psfp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .o_word_valid (o_word_valid),
        .i_word_ready (i_word_ready),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    // The datapath holds the frame, the sum and the output register.
    psfp_dpath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_rx_byte     (i_rx_byte),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_word_index  (o_word_index),
        .o_word_value  (o_word_value),
        .o_checksum_ok (o_checksum_ok),
        .o_last        (o_last)
    );

`ifndef ASSERT_OFF
    // Byte intake and word output never overlap.
    a_phase_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_rx_ready && o_word_valid))
        else $error("rx ready and word valid high together");

    // The last mark sits exactly on the final word index of a frame.
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word_valid |-> (o_last == (o_word_index == IDX_W'(NWORDS - 1))))
        else $error("last mark does not match word index");

    // After the final word transfer the core is ready for bytes again.
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word_valid && i_word_ready && o_last) |=> o_rx_ready)
        else $error("core not ready for bytes after the last word");

    // Within a burst the core keeps rx ready low.
    a_burst_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word_valid && i_word_ready && !o_last) |=> !o_rx_ready)
        else $error("rx ready raised in the middle of a word burst");
`endif

endmodule

>>> verif/tb_particle_sensor_frame_parser_core.sv
// ----------------------------------------------------------------------------
// tb_particle_sensor_frame_parser_core
// Self-checking bench for the particle sensor frame parser core.
// ----------------------------------------------------------------------------
// Received bytes are pushed into a queue by the stimulus process and handed
// to the core by a clocked driver. Every byte the core takes is run through a
// behavioral parser kept inside the bench, which queues the words the core
// must report when a frame closes. A clocked monitor pops one expected word
// per output transfer and compares every field. Both sides idle at random,
// and once the output side holds off long enough for the core to back up
// into its input. The start byte is reprogrammed between phases, only once
// the core has gone quiet.
// ----------------------------------------------------------------------------
module tb_particle_sensor_frame_parser_core;
    import psfp_pkg::*;

    // Frame geometry of the instance under test and the words one frame yields.
    localparam int FB = FRAME_BYTES_DEF;
    localparam int WORDS_PER_FRAME = ((FB - 2) / 2 > MAX_WORDS) ? MAX_WORDS : (FB - 2) / 2;

    // Cycles without any transfer before the run is declared hung. The worst
    // legal quiet stretch is the long output hold plus one stall and a word.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_BYTES    = 48;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [WORD_W-1:0] value;
        logic              sum_ok;
        logic              last;
    } t_parsed_word;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = '0;

    logic       rx_valid = 1'b0;
    logic [7:0] rx_byte  = '0;
    logic       rx_ready;

    logic              word_valid;
    logic              word_ready = 1'b0;
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] word_value;
    logic              checksum_ok;
    logic              word_last;

    particle_sensor_frame_parser_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_rx_valid    (rx_valid),
        .o_rx_ready    (rx_ready),
        .i_rx_byte     (rx_byte),
        .o_word_valid  (word_valid),
        .i_word_ready  (word_ready),
        .o_word_index  (word_index),
        .o_word_value  (word_value),
        .o_checksum_ok (checksum_ok),
        .o_last        (word_last)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Behavioral parser. It mirrors the core's frame state and produces the
    // word run of a frame the moment its final byte is taken.
    // ------------------------------------------------------------------------
    logic [7:0]   cur_start = START_BYTE_RST;
    logic [7:0]   frame_img [FB];
    int           frame_pos = 0;
    logic [15:0]  frame_sum = '0;
    t_parsed_word pending_words [$];

    task automatic take_rx_byte(input logic [7:0] b);
        logic [15:0]  check;
        t_parsed_word w;
        int           k;
        if (frame_pos == 0) begin
            // Idle: only the start byte opens a frame, everything else is dropped.
            if (b == cur_start) begin
                frame_img[0] = b;
                frame_sum    = {8'd0, b};
                frame_pos    = 1;
            end
        end else begin
            // Inside a frame every byte is data, a repeated start byte too.
            frame_img[frame_pos] = b;
            if (frame_pos < FB - 2) begin
                frame_sum = frame_sum + {8'd0, b};
            end
            frame_pos++;
            if (frame_pos == FB) begin
                check = {frame_img[FB - 2], frame_img[FB - 1]};
                for (k = 0; k < WORDS_PER_FRAME; k++) begin
                    w.index  = k[IDX_W-1:0];
                    w.value  = {frame_img[2 + 2 * k], frame_img[3 + 2 * k]};
                    w.sum_ok = (frame_sum == check);
                    w.last   = (k == WORDS_PER_FRAME - 1);
                    pending_words.push_back(w);
                end
                frame_pos = 0;
                frame_sum = '0;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus building. plan_pos follows the frame position the queued bytes
    // will leave the core in, so each phase can be closed on a frame boundary.
    // ------------------------------------------------------------------------
    logic [7:0] rx_byte_q [$];
    int         plan_pos = 0;

    task automatic push_byte(input logic [7:0] b);
        rx_byte_q.push_back(b);
        if (plan_pos == 0) begin
            if (b == cur_start) begin
                plan_pos = 1;
            end
        end else begin
            plan_pos++;
            if (plan_pos == FB) begin
                plan_pos = 0;
            end
        end
    endtask

    // Flavor 1 fills the payload with all ones, 2 with all zeros, 3 with the
    // start byte itself; anything else gives a mix weighted toward extremes.
    function automatic logic [7:0] pick_data(input int flavor);
        case (flavor)
            1: begin
                return 8'hFF;
            end
            2: begin
                return 8'h00;
            end
            3: begin
                return cur_start;
            end
            default: begin
                case ($urandom_range(0, 9))
                    0: return 8'h00;
                    1: return 8'hFF;
                    2: return cur_start;
                    default: return 8'($urandom_range(0, 255));
                endcase
            end
        endcase
    endfunction

    task automatic push_frame(input bit good_sum, input int flavor);
        logic [7:0]  img [FB];
        logic [15:0] s;
        int          i;
        img[0] = cur_start;
        // The second header byte is never checked by the core, so any value goes.
        img[1] = (flavor == 3) ? cur_start : 8'($urandom_range(0, 255));
        for (i = 2; i < FB - 2; i++) begin
            img[i] = pick_data(flavor);
        end
        s = '0;
        for (i = 0; i < FB - 2; i++) begin
            s = s + {8'd0, img[i]};
        end
        if (!good_sum) begin
            s = s ^ 16'($urandom_range(1, 65535));
        end
        img[FB - 2] = s[15:8];
        img[FB - 1] = s[7:0];
        for (i = 0; i < FB; i++) begin
            push_byte(img[i]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver. A new byte is offered only when the previous one has been
    // transferred, after the wait drawn for it. Stretches of back-to-back
    // offers alternate with stretches of random gaps.
    // ------------------------------------------------------------------------
    int rx_wait      = 0;
    int rx_mode_left = 0;
    bit rx_quiet     = 1'b0;

    function automatic int pick_wait(input bit quiet);
        if (quiet) begin
            return 0;
        end
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(0, 16);
        end
        return $urandom_range(0, 2);
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            rx_valid <= 1'b0;
            rx_byte  <= '0;
            rx_wait  <= 0;
        end else begin
            if (rx_valid && rx_ready) begin
                take_rx_byte(rx_byte);
            end
            if (!rx_valid || rx_ready) begin
                if (rx_wait > 0) begin
                    rx_valid <= 1'b0;
                    rx_wait  <= rx_wait - 1;
                end else if (rx_byte_q.size() > 0) begin
                    rx_valid <= 1'b1;
                    rx_byte  <= rx_byte_q.pop_front();
                    if (rx_mode_left == 0) begin
                        rx_quiet     = ($urandom_range(0, 2) == 0);
                        rx_mode_left = $urandom_range(10, 60);
                    end
                    rx_mode_left = rx_mode_left - 1;
                    rx_wait <= pick_wait(rx_quiet);
                end else begin
                    rx_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long output hold. Once armed it starts as soon as a word is waiting and
    // keeps the output side stalled while the driver keeps offering bytes.
    // ------------------------------------------------------------------------
    logic hold_arm   = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left  = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else if (hold_arm && !hold_taken && word_valid) begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Checks each word transfer against the oldest expected word and
    // draws the ready wait for the next one.
    // ------------------------------------------------------------------------
    int           error_cnt     = 0;
    int           word_wait     = 0;
    int           tx_mode_left  = 0;
    bit           tx_quiet      = 1'b0;
    t_parsed_word want;

    always @(posedge clk) begin
        if (!rst_n) begin
            word_ready <= 1'b0;
            word_wait = 0;
        end else begin
            if (word_valid && word_ready) begin
                if (pending_words.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= MAX_REPORTS) begin
                        $display("unexpected word: index %0d value %04h ok %0b last %0b",
                                 word_index, word_value, checksum_ok, word_last);
                    end
                end else begin
                    want = pending_words.pop_front();
                    if (word_index !== want.index || word_value !== want.value ||
                        checksum_ok !== want.sum_ok || word_last !== want.last) begin
                        error_cnt++;
                        if (error_cnt <= MAX_REPORTS) begin
                            $write("word mismatch: expected index %0d value %04h ",
                                   want.index, want.value);
                            $write("ok %0b last %0b, ", want.sum_ok, want.last);
                            $display("got index %0d value %04h ok %0b last %0b",
                                     word_index, word_value, checksum_ok, word_last);
                        end
                    end
                end
            end

            if (hold_left > 0) begin
                word_ready <= 1'b0;
            end else if (word_valid && word_ready) begin
                if (tx_mode_left == 0) begin
                    tx_quiet     = ($urandom_range(0, 2) == 0);
                    tx_mode_left = $urandom_range(5, 40);
                end
                tx_mode_left = tx_mode_left - 1;
                word_wait = pick_wait(tx_quiet);
                word_ready <= (word_wait == 0);
            end else if (word_wait > 0) begin
                word_wait = word_wait - 1;
                word_ready <= (word_wait == 0);
            end else begin
                word_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without a transfer on either channel ends the run.
    // ------------------------------------------------------------------------
    int stall_cycles = 0;

    always @(posedge clk) begin
        if ((rx_valid && rx_ready) || (word_valid && word_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_particle_sensor_frame_parser_core: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing.
    // ------------------------------------------------------------------------

    // Waits until every queued byte has been taken and every expected word
    // has arrived, then lets the core settle.
    task automatic wait_idle();
        @(negedge clk);
        while (rx_byte_q.size() != 0 || rx_valid || pending_words.size() != 0) begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic write_start(input logic [7:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        cur_start = v;
    endtask

    initial begin
        int          phase;
        int          fill;
        int          n;
        int          i;
        logic [7:0]  b;
        logic [7:0]  sb;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset start byte: bytes that idle detection
        // must drop, a frame of all-ones payload with a good checksum, an
        // all-zero payload with a broken checksum, and a frame whose header and
        // payload bytes all equal the start byte.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(~START_BYTE_RST);
        push_frame(1'b1, 1);
        push_frame(1'b0, 2);
        push_frame(1'b1, 3);
        wait_idle();

        // Random phases, each under its own start byte: the reset value, both
        // extremes, a random value and the reset value written back.
        for (phase = 0; phase < 5; phase++) begin
            if (phase > 0) begin
                case (phase)
                    1: sb = 8'h00;
                    2: sb = 8'hFF;
                    3: sb = 8'($urandom_range(0, 255));
                    default: sb = START_BYTE_RST;
                endcase
                write_start(sb);
            end
            if (phase == 2) begin
                hold_arm <= 1'b1;
            end
            fill = 0;
            while (fill < PHASE_BYTES) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        // Line noise between frames; it never opens a frame.
                        n = $urandom_range(1, 6);
                        for (i = 0; i < n; i++) begin
                            b = 8'($urandom_range(0, 255));
                            push_byte((b == cur_start) ? ~b : b);
                        end
                    end
                    2: begin
                        // A cut-off frame; the bytes after it are absorbed as
                        // its payload, so framing slips.
                        push_byte(cur_start);
                        n = $urandom_range(1, 24);
                        for (i = 0; i < n; i++) begin
                            push_byte(pick_data(0));
                        end
                        fill += n + 1;
                    end
                    default: begin
                        push_frame($urandom_range(0, 3) != 0, 0);
                        fill += FB;
                    end
                endcase
            end
            // Close any open frame so the core is idle before the next write.
            while (plan_pos != 0) begin
                push_byte(8'($urandom_range(0, 255)));
            end
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (error_cnt == 0) begin
            $display("tb_particle_sensor_frame_parser_core: clean");
        end else begin
            $display("tb_particle_sensor_frame_parser_core: errors");
        end
        $finish;
    end

endmodule
